>>> rtl/kllp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the keyed linked-list pool.
package kllp_pkg;

    localparam int NODES      = 16;
    localparam int DATA_BYTES = 8;
    localparam int IW         = $clog2(NODES);
    localparam int LW         = $clog2(NODES + 1);

    localparam logic [LW-1:0] NONE_MARK = LW'(NODES);
    localparam logic [63:0]   DATA_MASK = {64{1'b1}} >> (8 * (8 - DATA_BYTES));

    localparam logic [2:0] OP_INSERT    = 3'd0;
    localparam logic [2:0] OP_REMOVE    = 3'd1;
    localparam logic [2:0] OP_FIND      = 3'd2;
    localparam logic [2:0] OP_FIND_NEXT = 3'd3;
    localparam logic [2:0] OP_FIND_PREV = 3'd4;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_NOKEY  = 3'd2;
    localparam logic [2:0] ST_NONEXT = 3'd3;
    localparam logic [2:0] ST_NOPREV = 3'd4;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] key;
        logic [63:0] entry_data;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] found_data;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_INS_WR,
        S_INS_LINK,
        S_LK_RD,
        S_LK_CHK,
        S_DT_RD,
        S_DT_CHK,
        S_RESP
    } t_state;

    typedef struct packed {
        logic          kd_we;
        logic [IW-1:0] kd_addr;
        logic [15:0]   key;
        logic [63:0]   data;
        logic          prev_we;
        logic [IW-1:0] prev_addr;
        logic [LW-1:0] prev_val;
        logic          next_we;
        logic [IW-1:0] next_addr;
        logic [LW-1:0] next_val;
    } t_mem_wr;

    typedef struct packed {
        logic [15:0]   key;
        logic [63:0]   data;
        logic [LW-1:0] prev;
        logic [LW-1:0] next;
    } t_mem_rd;

endpackage

>>> rtl/kllp_mem.sv
`timescale 1ns / 1ps
// Slot storage: key, data and link memories with one shared read address and registered read data.
module kllp_mem (
    input  logic              i_clk,
    input  logic [kllp_pkg::IW-1:0] i_rd_addr,
    input  kllp_pkg::t_mem_wr i_wr,
    output kllp_pkg::t_mem_rd o_rd
);
    import kllp_pkg::*;

    logic [15:0]   r_key_mem  [NODES];
    logic [63:0]   r_data_mem [NODES];
    logic [LW-1:0] r_prev_mem [NODES];
    logic [LW-1:0] r_next_mem [NODES];
    t_mem_rd       r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.kd_we) begin
            r_key_mem[i_wr.kd_addr]  <= i_wr.key;
            r_data_mem[i_wr.kd_addr] <= i_wr.data;
        end
        if (i_wr.prev_we) begin
            r_prev_mem[i_wr.prev_addr] <= i_wr.prev_val;
        end
        if (i_wr.next_we) begin
            r_next_mem[i_wr.next_addr] <= i_wr.next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd.key  <= r_key_mem[i_rd_addr];
        r_rd.data <= r_data_mem[i_rd_addr];
        r_rd.prev <= r_prev_mem[i_rd_addr];
        r_rd.next <= r_next_mem[i_rd_addr];
    end

    assign o_rd = r_rd;

endmodule

>>> rtl/keyed_linked_list_pool.sv
`timescale 1ns / 1ps
// Keyed linked-list pool: sequencer, slot scan unit and result register.
// Full inserts and unused operation codes skip the scan and go straight to the result
// stage; other operations scan the slots, one slot a cycle through the single read port
// of the slot memory. The next item is taken only once the result is in the output
// register. Reset (synchronous) empties the list and clears control state only;
// slot memories are not cleared.
module keyed_linked_list_pool (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  kllp_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output kllp_pkg::t_out o_out
);
    import kllp_pkg::*;

    t_state        r_state, n_state;
    logic [NODES-1:0] r_occ;
    logic [LW-1:0] r_count, r_head, r_tail;
    logic [LW-1:0] r_idx;
    logic          r_pv;
    logic [IW-1:0] r_pidx, r_slot;
    logic [2:0]    r_op;
    logic [15:0]   r_key;
    logic [63:0]   r_wdata;
    logic [2:0]    r_status;
    logic [63:0]   r_found;
    logic          r_out_vld;
    t_out          r_out;

    t_mem_wr       mem_wr;
    t_mem_rd       mem_rd;
    logic [IW-1:0] rd_addr;

    logic          in_acc, out_free, full, hit, last, nonempty;
    logic [LW-1:0] lk, lk_p, lk_n;
    logic          lk_ok, p_ok, n_ok, nbr_op;

    kllp_mem u_mem (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .i_wr      (mem_wr),
        .o_rd      (mem_rd)
    );

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_vld || i_out_ready;
    assign full     = r_count >= LW'(NODES);
    assign nonempty = (r_head < NONE_MARK) && (r_tail < NONE_MARK);
    assign hit      = r_pv && ((r_op == OP_INSERT) ? !r_occ[r_pidx]
                                : (r_occ[r_pidx] && (mem_rd.key == r_key)));
    assign last     = r_pv && (r_pidx == IW'(NODES - 1));
    assign nbr_op   = (r_op == OP_FIND_NEXT) || (r_op == OP_FIND_PREV);
    assign lk       = (r_op == OP_FIND_NEXT) ? mem_rd.next : mem_rd.prev;
    assign lk_ok    = lk < NONE_MARK;
    assign p_ok     = mem_rd.prev < NONE_MARK;
    assign n_ok     = mem_rd.next < NONE_MARK;
    assign lk_p     = p_ok ? mem_rd.prev : NONE_MARK;
    assign lk_n     = n_ok ? mem_rd.next : NONE_MARK;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.operation == OP_INSERT && full) begin
                        n_state = S_RESP;
                    end else if (i_in.operation <= OP_FIND_PREV) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    if (r_op == OP_INSERT) begin
                        n_state = S_INS_WR;
                    end else if (r_op == OP_FIND) begin
                        n_state = S_DT_RD;
                    end else begin
                        n_state = S_LK_RD;
                    end
                end else if (last) begin
                    n_state = S_RESP;
                end
            end
            S_INS_WR:   n_state = S_INS_LINK;
            S_INS_LINK: n_state = S_RESP;
            S_LK_RD:    n_state = S_LK_CHK;
            S_LK_CHK: begin
                n_state = (nbr_op && lk_ok) ? S_DT_CHK : S_RESP;
            end
            S_DT_RD:    n_state = S_DT_CHK;
            S_DT_CHK:   n_state = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        rd_addr    = r_slot;
        mem_wr     = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_SCAN: begin
                rd_addr = r_idx[IW-1:0];
            end
            S_INS_WR: begin
                mem_wr.kd_we     = 1'b1;
                mem_wr.kd_addr   = r_slot;
                mem_wr.key       = r_key;
                mem_wr.data      = r_wdata & DATA_MASK;
                mem_wr.prev_we   = 1'b1;
                mem_wr.prev_addr = r_slot;
                mem_wr.prev_val  = nonempty ? r_tail : NONE_MARK;
                mem_wr.next_we   = 1'b1;
                mem_wr.next_addr = r_slot;
                mem_wr.next_val  = NONE_MARK;
            end
            S_INS_LINK: begin
                mem_wr.next_we   = nonempty;
                mem_wr.next_addr = r_tail[IW-1:0];
                mem_wr.next_val  = LW'(r_slot);
            end
            S_LK_CHK: begin
                rd_addr = lk[IW-1:0];
                if (r_op == OP_REMOVE) begin
                    mem_wr.next_we   = p_ok;
                    mem_wr.next_addr = mem_rd.prev[IW-1:0];
                    mem_wr.next_val  = lk_n;
                    mem_wr.prev_we   = n_ok;
                    mem_wr.prev_addr = mem_rd.next[IW-1:0];
                    mem_wr.prev_val  = lk_p;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_occ     <= '0;
            r_count   <= '0;
            r_head    <= NONE_MARK;
            r_tail    <= NONE_MARK;
            r_pv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_pv <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_pv <= r_idx < LW'(NODES);
            end
            if (r_state == S_INS_WR) begin
                r_occ[r_slot] <= 1'b1;
            end
            if (r_state == S_INS_LINK) begin
                r_tail  <= LW'(r_slot);
                r_count <= r_count + LW'(1);
                if (!nonempty) begin
                    r_head <= LW'(r_slot);
                end
            end
            if (r_state == S_LK_CHK && r_op == OP_REMOVE) begin
                r_occ[r_slot] <= 1'b0;
                if (r_count != '0) begin
                    r_count <= r_count - LW'(1);
                end
                if (!p_ok) begin
                    r_head <= lk_n;
                end
                if (!n_ok) begin
                    r_tail <= lk_p;
                end
            end
            if (r_state == S_RESP && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx    <= '0;
                r_op     <= i_in.operation;
                r_key    <= i_in.key;
                r_wdata  <= i_in.entry_data;
                r_found  <= '0;
                r_status <= (i_in.operation == OP_INSERT && full) ? ST_FULL : ST_OK;
            end
            S_SCAN: begin
                if (r_idx < LW'(NODES)) begin
                    r_idx <= r_idx + LW'(1);
                end
                r_pidx <= r_idx[IW-1:0];
                if (hit) begin
                    r_slot <= r_pidx;
                end else if (last) begin
                    r_status <= (r_op == OP_INSERT) ? ST_FULL : ST_NOKEY;
                end
            end
            S_LK_CHK: begin
                if (nbr_op && !lk_ok) begin
                    r_status <= (r_op == OP_FIND_NEXT) ? ST_NONEXT : ST_NOPREV;
                end
            end
            S_DT_CHK: begin
                r_found <= mem_rd.data;
            end
            S_RESP: begin
                if (out_free) begin
                    r_out.status     <= r_status;
                    r_out.found_data <= r_found;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LW'(NODES))
        else $error("entry count above capacity");

    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_occ) == 32'(r_count)))
        else $error("occupied flags disagree with count");

    a_head_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_head == NONE_MARK) == (r_count == '0)))
        else $error("head marker disagrees with count");

    a_tail_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_tail == NONE_MARK) == (r_count == '0)))
        else $error("tail marker disagrees with count");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_SCAN || r_state == S_RESP))
        else $error("accepted beat did not start work");

endmodule

>>> sim/keyed_linked_list_pool_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for keyed_linked_list_pool: directed and random beats, scoreboard.
module keyed_linked_list_pool_test;
    import kllp_pkg::*;

    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b0;
    t_in  i_in        = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out;

    // predicted pool contents
    logic [15:0]   pool_key  [NODES];
    logic [63:0]   pool_data [NODES];
    logic [LW-1:0] pool_prev [NODES];
    logic [LW-1:0] pool_next [NODES];
    bit            pool_used [NODES];
    logic [LW-1:0] list_head = NONE_MARK;
    logic [LW-1:0] list_tail = NONE_MARK;
    int            list_fill = 0;

    t_out awaited_replies[$];
    int   bad_replies = 0;
    bit   steady      = 1'b0;

    keyed_linked_list_pool DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(0, 99) >= 20);
    end

    function automatic logic [LW-1:0] slot_of(logic [15:0] k);
        for (int j = 0; j < NODES; j++) begin
            if (pool_used[j] && pool_key[j] == k) begin
                return LW'(j);
            end
        end
        return NONE_MARK;
    endfunction

    function automatic t_out list_reply(t_in cmd);
        t_out          r;
        logic [LW-1:0] s;
        logic [LW-1:0] p;
        logic [LW-1:0] n;
        logic [LW-1:0] l;
        int            free_slot;
        r.status     = ST_OK;
        r.found_data = '0;
        case (cmd.operation)
            OP_INSERT: begin
                free_slot = -1;
                if (list_fill < NODES) begin
                    for (int j = 0; j < NODES; j++) begin
                        if (!pool_used[j]) begin
                            free_slot = j;
                            break;
                        end
                    end
                end
                if (free_slot < 0) begin
                    r.status = ST_FULL;
                end else begin
                    pool_key[free_slot]  = cmd.key;
                    pool_data[free_slot] = cmd.entry_data & DATA_MASK;
                    pool_prev[free_slot] = NONE_MARK;
                    pool_next[free_slot] = NONE_MARK;
                    pool_used[free_slot] = 1'b1;
                    if (list_head >= NODES || list_tail >= NODES) begin
                        list_head = LW'(free_slot);
                        list_tail = LW'(free_slot);
                    end else begin
                        pool_next[list_tail] = LW'(free_slot);
                        pool_prev[free_slot] = list_tail;
                        list_tail            = LW'(free_slot);
                    end
                    list_fill++;
                end
            end
            OP_REMOVE: begin
                s = slot_of(cmd.key);
                if (s == NONE_MARK) begin
                    r.status = ST_NOKEY;
                end else begin
                    p = pool_prev[s];
                    n = pool_next[s];
                    if (p < NODES) begin
                        pool_next[p] = (n < NODES) ? n : NONE_MARK;
                    end else begin
                        list_head = (n < NODES) ? n : NONE_MARK;
                    end
                    if (n < NODES) begin
                        pool_prev[n] = (p < NODES) ? p : NONE_MARK;
                    end else begin
                        list_tail = (p < NODES) ? p : NONE_MARK;
                    end
                    pool_used[s] = 1'b0;
                    if (list_fill > 0) begin
                        list_fill--;
                    end
                end
            end
            OP_FIND, OP_FIND_NEXT, OP_FIND_PREV: begin
                s = slot_of(cmd.key);
                if (s == NONE_MARK) begin
                    r.status = ST_NOKEY;
                end else if (cmd.operation == OP_FIND) begin
                    r.found_data = pool_data[s];
                end else begin
                    l = (cmd.operation == OP_FIND_NEXT) ? pool_next[s] : pool_prev[s];
                    if (l < NODES) begin
                        r.found_data = pool_data[l];
                    end else begin
                        r.status = (cmd.operation == OP_FIND_NEXT) ? ST_NONEXT : ST_NOPREV;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_in make_beat(logic [2:0] op, logic [15:0] k, logic [63:0] d);
        t_in b;
        b.operation  = op;
        b.key        = k;
        b.entry_data = d;
        return b;
    endfunction

    function automatic t_in random_beat(int ins_pct, int rem_pct);
        int          roll;
        int          pick;
        int          start;
        logic [2:0]  op;
        logic [15:0] k;
        logic [63:0] d;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));
        end else if (roll < 3 + ins_pct) begin
            op = OP_INSERT;
        end else if (roll < 3 + ins_pct + rem_pct) begin
            op = OP_REMOVE;
        end else begin
            case ($urandom_range(0, 2))
                0:       op = OP_FIND;
                1:       op = OP_FIND_NEXT;
                default: op = OP_FIND_PREV;
            endcase
        end
        pick = $urandom_range(0, 99);
        k    = 16'($urandom);
        if (pick < 10) begin
            k = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end else if (pick < 35) begin
            k = 16'($urandom_range(0, 7));
        end else if (pick < 85 && op != OP_INSERT && list_fill != 0) begin
            start = $urandom_range(0, NODES - 1);
            for (int j = 0; j < NODES; j++) begin
                if (pool_used[(start + j) % NODES]) begin
                    k = pool_key[(start + j) % NODES];
                    break;
                end
            end
        end
        case ($urandom_range(0, 9))
            0:       d = '0;
            1:       d = '1;
            default: d = {$urandom, $urandom};
        endcase
        return make_beat(op, k, d);
    endfunction

    task automatic send_beat(input t_in beat);
        if (!steady) begin
            while ($urandom_range(0, 99) < 20) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in       <= beat;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        awaited_replies.push_back(list_reply(beat));
    endtask

    task automatic hold_until_replied();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_replies.size() != 0);
    endtask

    task automatic test_empty_list();
        send_beat(make_beat(OP_FIND, 16'h0000, '1));
        send_beat(make_beat(OP_REMOVE, 16'hFFFF, '0));
        send_beat(make_beat(OP_SPARE_B, 16'h0000, '0));
        send_beat(make_beat(OP_SPARE_C, 16'hFFFF, '1));
    endtask

    task automatic test_fill_to_capacity();
        logic [15:0] k;
        logic [63:0] d;
        for (int j = 0; j < NODES; j++) begin
            case (j)
                0: begin
                    k = 16'h0000;
                    d = '0;
                end
                1: begin
                    k = 16'hFFFF;
                    d = '1;
                end
                2: begin
                    k = 16'h1234;
                    d = 64'hA5A5_A5A5_A5A5_A5A5;
                end
                3: begin
                    k = 16'h1234;
                    d = 64'h5A5A_5A5A_5A5A_5A5A;
                end
                default: begin
                    k = 16'(16'h0100 + j);
                    d = {$urandom, $urandom};
                end
            endcase
            send_beat(make_beat(OP_INSERT, k, d));
        end
        send_beat(make_beat(OP_INSERT, 16'hBEEF, '1));
    endtask

    task automatic test_neighbors_and_duplicates();
        send_beat(make_beat(OP_FIND_PREV, 16'h0000, '0));
        send_beat(make_beat(OP_FIND_NEXT, 16'(16'h0100 + NODES - 1), '0));
        send_beat(make_beat(OP_FIND_NEXT, 16'h1234, '0));
        send_beat(make_beat(OP_REMOVE, 16'h1234, '0));
        send_beat(make_beat(OP_FIND_PREV, 16'h1234, '0));
        send_beat(make_beat(OP_INSERT, 16'h7777, 64'h0123_4567_89AB_CDEF));
        send_beat(make_beat(OP_FIND_NEXT, 16'(16'h0100 + NODES - 1), '0));
    endtask

    task automatic test_random_grow_shrink();
        int ins_mix [5] = '{60, 25, 10, 45, 20};
        int rem_mix [5] = '{10, 25, 55, 15, 40};
        for (int ph = 0; ph < 5; ph++) begin
            repeat (250) send_beat(random_beat(ins_mix[ph], rem_mix[ph]));
            if (ph == 2) begin
                hold_until_replied();
            end
        end
    endtask

    task automatic test_random_steady();
        steady = 1'b1;
        repeat (300) send_beat(random_beat(35, 25));
        steady = 1'b0;
    endtask

    always @(posedge i_clk) begin : reply_check
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_replies.size() == 0) begin
                bad_replies++;
                if (bad_replies <= 10) begin
                    $display("unexpected beat: status %0d data %h",
                             o_out.status, o_out.found_data);
                end
            end else begin
                want = awaited_replies.pop_front();
                if (o_out.status !== want.status || o_out.found_data !== want.found_data) begin
                    bad_replies++;
                    if (bad_replies <= 10) begin
                        $display("beat mismatch: status exp %0d got %0d, data exp %h got %h",
                                 want.status, o_out.status, want.found_data, o_out.found_data);
                    end
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_fill_to_capacity();
        test_neighbors_and_duplicates();
        hold_until_replied();
        test_random_grow_shrink();
        test_random_steady();
        hold_until_replied();
        repeat (NODES + 10) @(posedge i_clk);
        if (bad_replies == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
rtl/kllp_pkg.sv
rtl/kllp_mem.sv
rtl/keyed_linked_list_pool.sv
sim/keyed_linked_list_pool_test.sv
